FILE: src/nsqrt_pkg.sv
// Shared types and constants for the normalized Newton square root block.
package nsqrt_pkg;

    localparam int IN_W    = 32;  // radicand width, Q16.16
    localparam int FRAC_W  = 16;  // radicand and root fraction bits
    localparam int MANT_W  = 30;  // mantissa fraction bits, Q2.30
    localparam int X_W     = 32;  // iterate register width
    localparam int ROOT_W  = 25;
    localparam int CNT_W   = 6;
    localparam int TOL_W   = 31;
    localparam int SH_W    = 5;   // normalization shift count
    localparam int DCNT_W  = 5;   // divider bit counter
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W   = 31;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_STOP_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ITER_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 2'd2;

    localparam logic        RST_STOP_MODE  = 1'b1;
    localparam logic [CNT_W-1:0] RST_ITER_COUNT = 6'd6;
    localparam logic [TOL_W-1:0] RST_TOLERANCE  = 31'd16;

    // sqrt(2) in Q1.63, equally 1/sqrt(2) in Q0.64.
    localparam logic [63:0] SQRT2_BITS = 64'hB504F333F9DE6484;

    // Fraction bits dropped by the final shift before the exponent term.
    localparam int BASE_SHIFT = MANT_W - FRAC_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_NORM,
        ST_ITER,
        ST_DIV,
        ST_UPD,
        ST_ODD,
        ST_MUL0,
        ST_MUL1,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic norm_shift;
        logic div_start;
        logic div_step;
        logic upd;
        logic mul_lo;
        logic mul_hi;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_zero;
        logic norm_msb;
        logic step_ok;
        logic e_odd;
    } t_status;

endpackage

FILE: src/nsqrt_datapath.sv
// Datapath: normalizer, restoring divider, Newton update, sqrt2 multiply, final shift.
module nsqrt_datapath (
    input  logic                          i_clk,
    input  nsqrt_pkg::t_cmd               i_cmd,
    input  logic [nsqrt_pkg::IN_W-1:0]    i_radicand,
    input  logic [nsqrt_pkg::DCNT_W-1:0]  i_div_bit,
    input  logic [nsqrt_pkg::TOL_W-1:0]   i_tolerance,
    output nsqrt_pkg::t_status            o_status,
    output logic [nsqrt_pkg::ROOT_W-1:0]  o_root
);

    localparam int XW = nsqrt_pkg::X_W;
    localparam int MW = nsqrt_pkg::MANT_W;

    logic [nsqrt_pkg::IN_W-1:0]   r_norm;
    logic [nsqrt_pkg::SH_W-1:0]   r_sh;
    logic                         r_zero;
    logic [XW-1:0]                r_x;
    logic [XW:0]                  r_rem;
    logic [XW-1:0]                r_q;
    logic [63:0]                  r_acc;
    logic [nsqrt_pkg::ROOT_W-1:0] r_root;

    logic [MW-1:0]  w_m;
    logic           w_dbit;
    logic [XW+1:0]  w_rem_sh;
    logic           w_ge;
    logic [XW:0]    w_sum;
    logic [XW-1:0]  w_xn;
    logic [XW-1:0]  w_step;
    logic           w_e_pos;
    logic [63:0]    w_hi;
    logic [XW-1:0]  w_mul_res;
    logic signed [6:0] w_e;
    logic signed [6:0] w_half;
    logic [4:0]     w_shamt;
    logic [XW-1:0]  w_shifted;

    assign w_m = r_norm[nsqrt_pkg::IN_W-1 -: MW];

    always_comb begin
        // Dividend is m * 2^MANT_W; the remainder starts with m's upper bits, then m[1], m[0], zeros.
        if (i_div_bit == 5'd31) begin
            w_dbit = w_m[1];
        end else if (i_div_bit == 5'd30) begin
            w_dbit = w_m[0];
        end else begin
            w_dbit = 1'b0;
        end
        w_rem_sh = {r_rem, w_dbit};
        w_ge     = w_rem_sh >= {2'b00, r_x};
    end

    always_comb begin
        w_sum  = {1'b0, r_x} + {1'b0, r_q};
        w_xn   = w_sum[XW:1];
        if (w_xn == '0) begin
            w_xn = {{(XW-1){1'b0}}, 1'b1};
        end
        w_step = (w_xn > r_x) ? (w_xn - r_x) : (r_x - w_xn);
    end

    always_comb begin
        w_e     = 7'(nsqrt_pkg::IN_W - nsqrt_pkg::FRAC_W) - $signed({2'b00, r_sh});
        w_e_pos = (w_e > 7'sd0);
        if (w_e >= 0) begin
            w_half = w_e >>> 1;
        end else begin
            w_half = -((-w_e) >>> 1);
        end
        w_shamt   = 5'(7'(nsqrt_pkg::BASE_SHIFT) - 7'(w_half));
        w_shifted = r_x >> w_shamt;
    end

    assign w_hi      = (r_x * nsqrt_pkg::SQRT2_BITS[63:32]) + {32'd0, r_acc[63:32]};
    assign w_mul_res = w_e_pos ? w_hi[62:31] : w_hi[63:32];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_norm <= i_radicand;
            r_sh   <= '0;
            r_zero <= (i_radicand == '0);
        end else if (i_cmd.norm_shift) begin
            r_norm <= {r_norm[nsqrt_pkg::IN_W-2:0], 1'b0};
            r_sh   <= r_sh + 5'd1;
        end
        if (i_cmd.load) begin
            r_x <= XW'(1) << MW;
        end else if (i_cmd.upd) begin
            r_x <= w_xn;
        end else if (i_cmd.mul_hi) begin
            r_x <= w_mul_res;
        end
        if (i_cmd.div_start) begin
            r_rem <= {{(XW+1-(MW-2)){1'b0}}, w_m[MW-1:2]};
            r_q   <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? (XW+1)'(w_rem_sh - {2'b00, r_x}) : w_rem_sh[XW:0];
            r_q   <= {r_q[XW-2:0], w_ge};
        end
        if (i_cmd.mul_lo) begin
            r_acc <= r_x * nsqrt_pkg::SQRT2_BITS[31:0];
        end
        if (i_cmd.out_load) begin
            if (r_zero) begin
                r_root <= '0;
            end else if (w_shifted[XW-1:nsqrt_pkg::ROOT_W] != '0) begin
                r_root <= '1;
            end else begin
                r_root <= w_shifted[nsqrt_pkg::ROOT_W-1:0];
            end
        end
    end

    assign o_status.is_zero  = r_zero;
    assign o_status.norm_msb = r_norm[nsqrt_pkg::IN_W-1];
    assign o_status.step_ok  = w_step <= {1'b0, i_tolerance};
    assign o_status.e_odd    = r_sh[0];
    assign o_root = r_root;

endmodule

FILE: src/nsqrt_ctrl.sv
// Controller: sequencing state machine, iteration and divider counters, output flags.
module nsqrt_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  logic                          i_stop_mode,
    input  logic [nsqrt_pkg::CNT_W-1:0]   i_iter_count,
    input  nsqrt_pkg::t_status            i_status,
    output nsqrt_pkg::t_cmd               o_cmd,
    output logic [nsqrt_pkg::DCNT_W-1:0]  o_div_bit,
    output logic [nsqrt_pkg::CNT_W-1:0]   o_used,
    output logic                          o_conv
);

    nsqrt_pkg::t_state r_state, n_state;
    logic [nsqrt_pkg::DCNT_W-1:0] r_dcnt;
    logic [nsqrt_pkg::CNT_W-1:0]  r_used, r_out_used;
    logic r_conv, r_out_conv, r_out_valid;
    logic w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nsqrt_pkg::ST_IDLE:  if (i_in_valid) n_state = nsqrt_pkg::ST_CHECK;
            nsqrt_pkg::ST_CHECK: n_state = i_status.is_zero ? nsqrt_pkg::ST_FIN
                                                            : nsqrt_pkg::ST_NORM;
            nsqrt_pkg::ST_NORM:  if (i_status.norm_msb) n_state = nsqrt_pkg::ST_ITER;
            nsqrt_pkg::ST_ITER:  n_state = (r_used < i_iter_count) ? nsqrt_pkg::ST_DIV
                                                                   : nsqrt_pkg::ST_ODD;
            nsqrt_pkg::ST_DIV:   if (r_dcnt == '0) n_state = nsqrt_pkg::ST_UPD;
            nsqrt_pkg::ST_UPD:   n_state = (!i_stop_mode && i_status.step_ok)
                                           ? nsqrt_pkg::ST_ODD : nsqrt_pkg::ST_ITER;
            nsqrt_pkg::ST_ODD:   n_state = i_status.e_odd ? nsqrt_pkg::ST_MUL0
                                                          : nsqrt_pkg::ST_FIN;
            nsqrt_pkg::ST_MUL0:  n_state = nsqrt_pkg::ST_MUL1;
            nsqrt_pkg::ST_MUL1:  n_state = nsqrt_pkg::ST_FIN;
            nsqrt_pkg::ST_FIN:   if (w_out_free) n_state = nsqrt_pkg::ST_IDLE;
            default:             n_state = nsqrt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            nsqrt_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            nsqrt_pkg::ST_NORM: o_cmd.norm_shift = !i_status.norm_msb;
            nsqrt_pkg::ST_ITER: o_cmd.div_start  = (r_used < i_iter_count);
            nsqrt_pkg::ST_DIV:  o_cmd.div_step   = 1'b1;
            nsqrt_pkg::ST_UPD:  o_cmd.upd        = 1'b1;
            nsqrt_pkg::ST_MUL0: o_cmd.mul_lo     = 1'b1;
            nsqrt_pkg::ST_MUL1: o_cmd.mul_hi     = 1'b1;
            nsqrt_pkg::ST_FIN:  o_cmd.out_load   = w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nsqrt_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_dcnt      <= '0;
            r_used      <= '0;
            r_conv      <= 1'b0;
            r_out_used  <= '0;
            r_out_conv  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load) begin
                r_used <= '0;
                r_conv <= i_stop_mode;
            end
            if (r_state == nsqrt_pkg::ST_CHECK && i_status.is_zero) begin
                r_conv <= 1'b1;
            end
            if (o_cmd.div_start) begin
                r_dcnt <= '1;
            end else if (o_cmd.div_step) begin
                r_dcnt <= r_dcnt - 5'd1;
            end
            if (o_cmd.upd) begin
                r_used <= r_used + 6'd1;
                if (!i_stop_mode && i_status.step_ok) begin
                    r_conv <= 1'b1;
                end
            end
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
                r_out_used  <= r_used;
                r_out_conv  <= r_conv;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_div_bit   = r_dcnt;
    assign o_out_valid = r_out_valid;
    assign o_used      = r_out_used;
    assign o_conv      = r_out_conv;

endmodule

FILE: src/newton_sqrt_normalized.sv
// Top level of the normalized Newton-Raphson square root block.
//
// Channel   Direction  Contents
// s_axis    in         tdata[31:0] radicand (Q16.16)
// m_axis    out        tdata[24:0] root, [30:25] iterations_used, [31] converged
// cfg       in         index 0 stop_mode, 1 iteration_count, 2 tolerance
//
// The time from acceptance to a valid result grows with the leading zeros and with each
// Newton iteration, is shorter when the tolerance ends the loop and longer when the
// exponent is odd; the restoring divider takes most of it. A zero radicand skips
// normalization and iteration. Reset is synchronous and active low.
// A finished result waits in the output register; the block takes the next request
// while it waits and stalls only when a second result is ready before the first leaves.
module newton_sqrt_normalized (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // radicand
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // root, iterations_used, converged
    input  logic        i_cfg_wr_en,
    input  logic [nsqrt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nsqrt_pkg::CFG_W-1:0]     i_cfg_data
);

    logic                         r_stop_mode;
    logic [nsqrt_pkg::CNT_W-1:0]  r_iter_count;
    logic [nsqrt_pkg::TOL_W-1:0]  r_tolerance;

    nsqrt_pkg::t_cmd              w_cmd;
    nsqrt_pkg::t_status           w_status;
    logic [nsqrt_pkg::DCNT_W-1:0] w_div_bit;
    logic [nsqrt_pkg::CNT_W-1:0]  w_used;
    logic                         w_conv;
    logic [nsqrt_pkg::ROOT_W-1:0] w_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_mode  <= nsqrt_pkg::RST_STOP_MODE;
            r_iter_count <= nsqrt_pkg::RST_ITER_COUNT;
            r_tolerance  <= nsqrt_pkg::RST_TOLERANCE;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                nsqrt_pkg::REG_STOP_MODE:  r_stop_mode  <= i_cfg_data[0];
                nsqrt_pkg::REG_ITER_COUNT: r_iter_count <= i_cfg_data[nsqrt_pkg::CNT_W-1:0];
                nsqrt_pkg::REG_TOLERANCE:  r_tolerance  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    nsqrt_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_stop_mode  (r_stop_mode),
        .i_iter_count (r_iter_count),
        .i_status     (w_status),
        .o_cmd        (w_cmd),
        .o_div_bit    (w_div_bit),
        .o_used       (w_used),
        .o_conv       (w_conv)
    );

    nsqrt_datapath u_dp (
        .i_clk       (i_clk),
        .i_cmd       (w_cmd),
        .i_radicand  (s_axis_tdata),
        .i_div_bit   (w_div_bit),
        .i_tolerance (r_tolerance),
        .o_status    (w_status),
        .o_root      (w_root)
    );

    assign m_axis_tdata = {w_conv, w_used, w_root};

    // Non-convergence can only be reported in tolerance mode.
    a_conv_fixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[31]) |-> !r_stop_mode)
        else $error("non-converged result in fixed-count mode");

    // The iteration count never exceeds the configured cap.
    a_used_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[30:25] <= r_iter_count))
        else $error("iterations_used above cap");

    // A new request is never taken in the cycle right after one was accepted.
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while busy");

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the normalized Newton square root block.
module tb;

    localparam logic MODE_TOL   = 1'b0;
    localparam logic MODE_FIXED = 1'b1;
    localparam int   WATCHDOG_LIMIT = 12000;
    localparam logic [63:0] ROOT_MAX = (64'd1 << nsqrt_pkg::ROOT_W) - 1;

    class sqrt_scoreboard;
        logic                        stop_mode;
        logic [nsqrt_pkg::CNT_W-1:0] iter_cap;
        logic [nsqrt_pkg::TOL_W-1:0] tol;
        logic [31:0]                 expected_roots[$];
        int                          mismatches;

        function new();
            stop_mode = nsqrt_pkg::RST_STOP_MODE;
            iter_cap  = nsqrt_pkg::RST_ITER_COUNT;
            tol       = nsqrt_pkg::RST_TOLERANCE;
            mismatches = 0;
        endfunction

        function logic [31:0] compute_root(logic [31:0] rad);
            int p, e, half, s, used;
            logic [63:0] mant, x, xn, step_size, root;
            logic [127:0] prod;
            logic conv;
            if (rad == 0) return {1'b1, 6'd0, 25'd0};
            p = 31;
            while (p > 0 && !rad[p]) p--;
            e = p + 1 - 16;
            if (p + 1 > nsqrt_pkg::MANT_W) mant = 64'(rad) >> (p + 1 - nsqrt_pkg::MANT_W);
            else mant = 64'(rad) << (nsqrt_pkg::MANT_W - p - 1);
            x = 64'd1 << nsqrt_pkg::MANT_W;
            used = 0;
            conv = 0;
            if (stop_mode == MODE_FIXED) begin
                conv = 1;
                for (used = 0; used < iter_cap; used++) begin
                    x = (x + (mant << nsqrt_pkg::MANT_W) / x) >> 1;
                    if (x == 0) x = 1;
                end
            end else begin
                while (used < iter_cap) begin
                    xn = (x + (mant << nsqrt_pkg::MANT_W) / x) >> 1;
                    if (xn == 0) xn = 1;
                    step_size = (xn > x) ? xn - x : x - xn;
                    x = xn;
                    used++;
                    if (step_size <= 64'(tol)) begin
                        conv = 1;
                        break;
                    end
                end
            end
            // Odd exponent: scale by sqrt2 or its inverse, same constant bits.
            if (e % 2 != 0) begin
                prod = 128'(x) * 128'(nsqrt_pkg::SQRT2_BITS);
                x = (e > 0) ? 64'(prod >> 63) : 64'(prod >> 64);
            end
            half = e / 2;
            s = 16 + half - nsqrt_pkg::MANT_W;
            if (s >= 0) begin
                if (s >= 64 || (x >> (63 - s)) > 1) root = ROOT_MAX;
                else root = x << s;
            end else begin
                root = (-s >= 64) ? 64'd0 : (x >> (-s));
            end
            if (root > ROOT_MAX) root = ROOT_MAX;
            return {conv, 6'(used), root[nsqrt_pkg::ROOT_W-1:0]};
        endfunction

        function void note_request(logic [31:0] rad);
            expected_roots.push_back(compute_root(rad));
        endfunction

        function void check_result(logic [31:0] got);
            logic [31:0] want;
            if (expected_roots.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            want = expected_roots.pop_front();
            if (got[24:0] !== want[24:0] || got[30:25] !== want[30:25]
                    || got[31] !== want[31]) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: root %h/%h iters %0d/%0d conv %b/%b (exp/act)",
                             want[24:0], got[24:0], want[30:25], got[30:25],
                             want[31], got[31]);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        i_cfg_wr_en;
    logic [nsqrt_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [nsqrt_pkg::CFG_W-1:0]     i_cfg_data;

    sqrt_scoreboard sb = new();
    int idle_cycles = 0;
    int burst_left = 0;

    newton_sqrt_normalized i_dut (.*);

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // Monitor: requests and results are sampled before this edge's updates land.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    // Receiver stalls follow a pattern that changes every so often.
    int stall_kind = 0;
    int stall_age = 0;
    always @(posedge i_clk) begin
        if (stall_age == 0) begin
            stall_kind <= $urandom_range(0, 3);
            stall_age  <= $urandom_range(50, 400);
        end else begin
            stall_age <= stall_age - 1;
        end
        case (stall_kind)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 1) == 1);
            2: m_axis_tready <= ($urandom_range(0, 7) == 0);
            default: m_axis_tready <= (stall_age % 16) < 8;
        endcase
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || i_cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL newton_sqrt_normalized");
            $finish;
        end
    end

    task automatic send_radicand(input logic [31:0] rad);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
            if (gap > 0 && s_axis_tvalid) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rad;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // The first edge lets the monitor record a request accepted at the previous edge.
    task automatic drain();
        if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_roots.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [nsqrt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [nsqrt_pkg::CFG_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            nsqrt_pkg::REG_STOP_MODE:  sb.stop_mode = val[0];
            nsqrt_pkg::REG_ITER_COUNT: sb.iter_cap  = val[nsqrt_pkg::CNT_W-1:0];
            nsqrt_pkg::REG_TOLERANCE:  sb.tol       = val[nsqrt_pkg::TOL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_mode(input logic mode, input int cap, input logic [30:0] tol);
        drain();
        write_reg(nsqrt_pkg::REG_STOP_MODE, 31'(mode));
        write_reg(nsqrt_pkg::REG_ITER_COUNT, 31'(cap));
        write_reg(nsqrt_pkg::REG_TOLERANCE, tol);
    endtask

    function automatic logic [31:0] random_radicand();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'd1 << $urandom_range(0, 31);
            2: return ($urandom | 32'h8000_0000) >> $urandom_range(0, 31);
            3: return ($urandom_range(0, 40) == 0) ? 32'd0 : $urandom >> $urandom_range(16, 31);
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    task automatic random_items(input int n);
        for (int i = 0; i < n; i++) begin
            send_radicand(random_radicand());
            if (i == n / 2 && $urandom_range(0, 1) == 1) drain();
        end
    endtask

    logic [31:0] directed[] = '{32'd0, 32'd1, 32'd2, 32'd3, 32'hFFFF_FFFF, 32'h8000_0000,
        32'h0001_0000, 32'h0002_0000, 32'h0004_0000, 32'h0000_8000, 32'h0000_FFFF,
        32'h0001_FFFF, 32'h3FFF_FFFF, 32'h4000_0000, 32'h7FFF_FFFF, 32'h5555_5555,
        32'hAAAA_AAAA, 32'h0000_0100, 32'h0009_0000, 32'h0000_4000};

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) send_radicand(directed[i]);
        random_items(60);

        set_mode(MODE_TOL, 20, 31'd16);
        foreach (directed[i]) send_radicand(directed[i]);
        random_items(80);
        set_mode(MODE_FIXED, 0, 31'd0);
        random_items(40);
        set_mode(MODE_FIXED, 63, 31'h4000_0000);
        random_items(15);
        set_mode(MODE_TOL, 0, 31'd100);
        random_items(40);
        set_mode(MODE_TOL, 63, 31'd0);
        random_items(30);
        set_mode(MODE_TOL, 5, 31'h4000_0000);
        random_items(60);
        set_mode(MODE_TOL, 10, 31'h7FFF_FFFF);
        random_items(40);
        for (int k = 0; k < 4; k++) begin
            set_mode(($urandom_range(0, 1) == 1) ? MODE_FIXED : MODE_TOL,
                     $urandom_range(1, 12), 31'($urandom_range(0, 1 << $urandom_range(0, 30))));
            random_items(35);
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_roots.size() == 0)
            $display("PASS newton_sqrt_normalized");
        else
            $display("FAIL newton_sqrt_normalized");
        $finish;
    end
endmodule

FILE: filelist.f
src/nsqrt_pkg.sv
src/nsqrt_datapath.sv
src/nsqrt_ctrl.sv
src/newton_sqrt_normalized.sv
sim/tb.sv
